[src/pidt_pkg.sv]
// Shared types and constants for the trapezoidal PID regulator.
package pidt_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_OUT_LIM   = 3'd3;
    localparam logic [2:0] REG_INT_LIM   = 3'd4;
    localparam logic [2:0] REG_TOL       = 3'd5;
    localparam logic [2:0] REG_MODE      = 3'd6;

    localparam int CMD_START = 1;

    // request to the serial multiply/divide unit
    typedef struct packed {
        logic start;
        logic div;
    } t_ser_req;

endpackage

[src/pidt_serial_unit.sv]
// Bit-serial unsigned multiplier and restoring divider, one bit per cycle.
module pidt_serial_unit #(
    parameter int W = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pidt_pkg::t_ser_req  i_req,
    input  logic [W-1:0]        i_a,
    input  logic [W-1:0]        i_b,
    output logic                o_done,
    output logic [2*W-1:0]      o_res
);
    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] r_acc, n_acc;
    logic [W-1:0]   r_b, n_b;
    logic [W:0]     r_rem, n_rem;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_busy, n_busy, r_div, n_div, r_done, n_done;
    logic [W:0]     w_trial;
    logic [W:0]     w_hsum;

    // one shift-and-add or shift-and-subtract step a cycle
    always_comb begin
        n_acc = r_acc; n_b = r_b; n_rem = r_rem; n_cnt = r_cnt;
        n_busy = r_busy; n_div = r_div; n_done = 1'b0;
        w_trial = {r_rem[W-1:0], r_acc[W-1]} - {1'b0, r_b};
        w_hsum = '0;
        if (i_req.start) begin
            n_acc = {{W{1'b0}}, i_a}; n_b = i_b; n_rem = '0;
            n_cnt = CW'(W); n_busy = 1'b1; n_div = i_req.div;
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_trial[W]) begin
                    n_rem = w_trial;
                    n_acc = {r_acc[2*W-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[W-1:0], r_acc[W-1]};
                    n_acc = {r_acc[2*W-2:0], 1'b0};
                end
            end else begin
                // add the multiplicand into the upper half, then shift right
                w_hsum = {1'b0, r_acc[2*W-1:W]} + {1'b0, (r_acc[0] ? r_b : {W{1'b0}})};
                n_acc = {w_hsum, r_acc[W-1:1]};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0; r_div <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt; r_div <= n_div;
        end
        r_acc <= n_acc; r_b <= n_b; r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_res  = r_div ? {{W{1'b0}}, r_acc[W-1:0]} : r_acc;

    // a finish never comes without work in progress
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_done |-> r_busy) else $error("finish without work");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("busy with empty count");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("start lost");
endmodule

[src/pid_controller_trapezoidal_unit.sv]
// Top level of the trapezoidal PID regulator.
// channel   direction  tdata (low bit up)                          tuser
// s_axis    in         target, measured, time_now                  cmd
// m_axis    out        drive, integrator_value                     within_tol, zero_iv
// cfg       in         index i_cfg_index, data i_cfg_data          -
// An update makes five passes of the bit-serial unit (trapezoid product, secant
// divide, three gain products) and five single steps (wait, prep, clamp, sum, out)
// on its way from the request to the output.
// A start item goes from idle to the wait state, which loads a zero result and clears
// the state once the output register is free; no request is taken in the meantime.
// Reset is synchronous, active low, and clears the state at the clock edge.
// A held result lets the next request in; its sequence stalls at the last step
// until the held result is taken.
module pid_controller_trapezoidal_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [3*DATA_WIDTH-1:0] s_axis_tdata,  // target, measured, time_now
    input  logic                    s_axis_tuser,  // cmd
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [2*DATA_WIDTH-1:0] m_axis_tdata,  // drive, integrator_value
    output logic [1:0]              m_axis_tuser,  // within_tolerance, zero_interval
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [2*DATA_WIDTH-1:0] i_cfg_data
);
    localparam int W  = DATA_WIDTH;
    localparam int MW = 2 * W + 2;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_PREP = 4'd1, ST_TRAP = 4'd2,
        ST_DIV = 4'd3, ST_CLAMP = 4'd4, ST_MP = 4'd5, ST_MI = 4'd6,
        ST_MD = 4'd7, ST_SUM = 4'd8, ST_OUT = 4'd9, ST_WAIT = 4'd10;

    localparam logic signed [MW-1:0] SMAX = MW'((64'sd1 <<< (W-1)) - 1);
    localparam logic signed [MW-1:0] SMIN = -MW'(64'sd1 <<< (W-1));
    localparam logic [MW-1:0] ULIM = MW'(64'd1 << (W-1));

    // configuration
    logic signed [W-1:0] r_gp, r_gi, r_gd;
    logic [2*W-1:0] r_olim, r_ilim, r_tol;
    logic [1:0] r_mode;
    // state
    logic signed [W-1:0] r_isum, r_pmeas;
    logic [W-1:0] r_ptime;
    // working
    logic [3:0] r_st;
    logic signed [W-1:0] r_tgt, r_meas, r_e, r_pe, r_der, r_drive;
    logic [W-1:0] r_now, r_dt;
    logic signed [MW-1:0] r_sum;
    logic r_neg, r_zero, r_within, r_cmd;
    logic [2*W-1:0] r_odata;
    logic [1:0] r_ouser;
    logic r_oval;

    pidt_pkg::t_ser_req w_req;
    logic [MW-1:0] w_a, w_b;
    logic w_done;
    logic [2*MW-1:0] w_res;

    pidt_serial_unit #(.W(MW)) u_ser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .i_a(w_a), .i_b(w_b),
        .o_done(w_done), .o_res(w_res));

    function automatic logic signed [MW-1:0] sat(input logic signed [MW-1:0] x);
        if (x > SMAX) return SMAX;
        if (x < SMIN) return SMIN;
        return x;
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] x);
        return x[MW-1] ? MW'(-x) : x;
    endfunction

    // shifted magnitude to saturated signed value
    function automatic logic signed [MW-1:0] fin(input logic [2*MW-1:0] p,
            input int sh, input logic neg);
        logic [2*MW-1:0] q;
        q = p >> sh;
        if (q >= {{MW{1'b0}}, ULIM}) return neg ? SMIN : SMAX;
        return neg ? -$signed(q[MW-1:0]) : $signed(q[MW-1:0]);
    endfunction

    logic signed [MW-1:0] w_ext_e, w_ext_pe, w_fin, w_imax, w_imin, w_acc;
    logic signed [MW-1:0] w_mp;
    assign w_ext_e  = MW'(r_e);
    assign w_ext_pe = MW'(r_pe);
    assign w_imax = MW'($signed(r_ilim[2*W-1:W]));
    assign w_imin = MW'($signed(r_ilim[W-1:0]));

    // operands for the shared unit
    always_comb begin
        w_req = '0; w_a = '0; w_b = '0;
        w_mp = '0;
        unique case (r_st)
            ST_PREP: begin
                w_mp = w_ext_e + w_ext_pe;
                w_req.start = 1'b1; w_a = mag(w_mp); w_b = MW'(r_dt);
            end
            ST_TRAP: if (w_done) begin
                w_mp = w_ext_e - w_ext_pe;
                w_req.start = 1'b1; w_req.div = 1'b1;
                w_a = mag(w_mp) << FRAC_BITS;
                w_b = (r_dt == '0) ? MW'(1) : MW'(r_dt);
            end
            ST_CLAMP: begin
                w_req.start = 1'b1; w_a = mag(MW'(r_gp)); w_b = mag(w_ext_e);
            end
            ST_MP: if (w_done) begin
                w_req.start = 1'b1; w_a = mag(MW'(r_gi)); w_b = mag(MW'(r_isum));
            end
            ST_MI: if (w_done) begin
                w_req.start = 1'b1; w_a = mag(MW'(r_gd)); w_b = mag(MW'(r_der));
            end
            default: ;
        endcase
    end

    always_comb begin
        w_fin = '0;
        unique case (r_st)
            ST_TRAP: w_fin = fin(w_res, FRAC_BITS + 1, r_neg);
            ST_DIV:  w_fin = fin(w_res, 0, r_neg);
            default: w_fin = fin(w_res, FRAC_BITS, r_neg);
        endcase
    end
    assign w_acc = sat(r_sum + w_fin);

    logic w_take;
    logic w_out_free, w_load;
    assign w_take = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    // output register free now, or emptied at this edge
    assign w_out_free = !r_oval || (m_axis_tvalid && m_axis_tready);
    assign w_load = w_out_free && ((r_st == ST_OUT) ||
        ((r_st == ST_WAIT) && (r_cmd == 1'(pidt_pkg::CMD_START))));

    // control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_oval <= 1'b0;
            r_gp <= '0; r_gi <= '0; r_gd <= '0;
            r_olim <= {W'(1 << FRAC_BITS), W'(-(1 << FRAC_BITS))};
            r_ilim <= {W'(-(1 << FRAC_BITS)), W'(1 << FRAC_BITS)};
            r_tol <= '0; r_mode <= 2'd1;
            r_isum <= '0; r_pmeas <= '0; r_ptime <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && !w_load) r_oval <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pidt_pkg::REG_GAIN_P:  r_gp <= i_cfg_data[W-1:0];
                    pidt_pkg::REG_GAIN_I:  r_gi <= i_cfg_data[W-1:0];
                    pidt_pkg::REG_GAIN_D:  r_gd <= i_cfg_data[W-1:0];
                    pidt_pkg::REG_OUT_LIM: r_olim <= i_cfg_data;
                    pidt_pkg::REG_INT_LIM: r_ilim <= i_cfg_data;
                    pidt_pkg::REG_TOL:     r_tol <= i_cfg_data;
                    pidt_pkg::REG_MODE:    r_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            unique case (r_st)
                ST_IDLE: if (w_take) begin
                    r_cmd  <= s_axis_tuser;
                    r_tgt  <= s_axis_tdata[W-1:0];
                    r_meas <= s_axis_tdata[2*W-1:W];
                    r_now  <= s_axis_tdata[3*W-1:2*W];
                    r_st   <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (r_cmd == 1'(pidt_pkg::CMD_START)) begin
                        if (w_out_free) begin
                            r_isum <= '0; r_pmeas <= r_meas; r_ptime <= '0;
                            r_odata <= '0; r_ouser <= '0; r_oval <= 1'b1;
                            r_st <= ST_IDLE;
                        end
                    end else begin
                        r_dt <= r_now - r_ptime;
                        r_e  <= W'(sat(MW'(r_tgt) - MW'(r_meas)));
                        r_pe <= W'(sat(MW'(r_tgt) - MW'(r_pmeas)));
                        r_st <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_neg <= w_mp[MW-1];
                    r_zero <= (r_dt == '0);
                    r_st <= ST_TRAP;
                end
                ST_TRAP: if (w_done) begin
                    r_isum <= W'(sat(MW'(r_isum) + w_fin));
                    r_neg <= w_mp[MW-1];
                    r_st <= ST_DIV;
                end
                ST_DIV: if (w_done) begin
                    r_der <= r_zero ? '0 : W'(w_fin);
                    r_st <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    if (w_imax > w_imin) begin
                        if (MW'(r_isum) < w_imin) r_isum <= W'(w_imin);
                        else if (MW'(r_isum) > w_imax) r_isum <= W'(w_imax);
                    end
                    r_neg <= r_gp[W-1] ^ r_e[W-1];
                    r_sum <= '0;
                    r_st <= ST_MP;
                end
                ST_MP: if (w_done) begin
                    r_sum <= r_sum + w_fin;
                    r_neg <= r_gi[W-1] ^ r_isum[W-1];
                    r_st <= ST_MI;
                end
                ST_MI: if (w_done) begin
                    r_sum <= r_sum + w_fin;
                    r_neg <= r_gd[W-1] ^ r_der[W-1];
                    r_st <= ST_MD;
                end
                ST_MD: if (w_done) begin
                    r_sum <= w_acc;
                    r_st <= ST_SUM;
                end
                ST_SUM: begin
                    r_within <= 1'b0;
                    if (r_mode[1] && $signed(mag(w_ext_e)) < MW'($signed(r_tol[W-1:0]))
                        && $signed(mag(MW'(r_der))) < MW'($signed(r_tol[2*W-1:W]))) begin
                        r_drive <= '0; r_within <= 1'b1;
                    end else if (r_mode[0]) begin
                        // inverted limits: the high limit wins
                        if (r_sum > MW'($signed(r_olim[2*W-1:W])) ||
                            $signed(r_olim[W-1:0]) > $signed(r_olim[2*W-1:W]))
                            r_drive <= r_olim[2*W-1:W];
                        else if (r_sum < MW'($signed(r_olim[W-1:0])))
                            r_drive <= r_olim[W-1:0];
                        else r_drive <= W'(r_sum);
                    end else r_drive <= W'(r_sum);
                    r_st <= ST_OUT;
                end
                ST_OUT: if (w_out_free) begin
                    r_odata <= {r_isum, r_drive};
                    r_ouser <= {r_zero, r_within};
                    r_oval <= 1'b1;
                    r_pmeas <= r_meas; r_ptime <= r_now;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    a_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_st == ST_WAIT) else $error("item not taken up");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_OUT |=> r_oval) else $error("result lost");
    a_zero_der: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_CLAMP && r_zero |-> r_der == '0) else $error("derivative on zero dt");
endmodule
